// File: rtl/rfpbl_pkg.sv
// shared types and constants for the pulse bucket learner and decoder
package rfpbl_pkg;

  localparam int DUR_W          = 16;
  localparam int SUM_W          = 18;
  localparam int KIND_W         = 3;
  localparam int POS_W          = 8;
  localparam int MODE_W         = 2;
  localparam int NIB_W          = 4;
  localparam int CFG_IDX_W      = 2;

  localparam int NUM_BUCKETS_DEF = 16;
  localparam int MAX_BYTES_DEF   = 128;

  localparam logic [DUR_W-1:0] FOOTER_RST = 16'd3000;
  localparam logic [DUR_W-1:0] PULSE_RST  = 16'd100;
  localparam logic [NIB_W-1:0] NIB_MASK   = 4'hF;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FOOTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 2'd1;

  localparam logic [KIND_W-1:0] KIND_STATUS = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BUCKET = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FEND   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ABORT  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEARN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DONE   = 2'd3;

  typedef struct packed {
    logic load;
    logic avg;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/rfpbl_bucket_cell.sv
// one timing bucket: holds its time, matches a pulse, averages, shifts to its neighbour
module rfpbl_bucket_cell (
  input  logic                      clk,
  input  rfpbl_pkg::cell_ctl_t      ctl,
  input  logic [rfpbl_pkg::DUR_W-1:0] dur,
  input  logic [rfpbl_pkg::SUM_W-1:0] delta,
  input  logic [rfpbl_pkg::DUR_W-1:0] shift_in,
  output logic [rfpbl_pkg::DUR_W-1:0] time_q,
  output logic                      match_r
);
  import rfpbl_pkg::*;

  logic [DUR_W-1:0] time_r;
  logic [DUR_W-1:0] time_nxt;
  logic [SUM_W-1:0] avg_sum;
  logic             match_nxt;

  assign avg_sum   = SUM_W'(time_r) + SUM_W'(dur);
  assign match_nxt = (SUM_W'(time_r) < SUM_W'(dur) + delta) &&
                     (SUM_W'(dur) < SUM_W'(time_r) + delta);

  always_comb begin
    time_nxt = time_r;
    if (ctl.load) begin
      time_nxt = dur;
    end else if (ctl.avg) begin
      time_nxt = avg_sum[DUR_W:1];
    end else if (ctl.shift) begin
      time_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    time_r  <= time_nxt;
    match_r <= match_nxt;
  end

  assign time_q = time_r;

endmodule

// File: rtl/rf_pulse_bucket_learner_decoder_top.sv
// top level: sequencer, configuration registers and the row of bucket cells
// an accepted item is registered, matched in S_MATCH and emitted from S_EXEC
// items are taken only in S_IDLE; a frame end emits the buckets in use, then KIND_FEND
// the bucket table is read out by shifting it down the cell row, one bucket per cycle
// unless stalled; output stall adds cycles only while a result is pending
// reset: synchronous rst_n clears mode, counters and config to defaults; bucket times hold
module rf_pulse_bucket_learner_decoder_top #(
  parameter int NUM_BUCKETS = rfpbl_pkg::NUM_BUCKETS_DEF,
  parameter int MAX_BYTES   = rfpbl_pkg::MAX_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [rfpbl_pkg::DUR_W-1:0]     in_duration,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rfpbl_pkg::KIND_W-1:0]    out_kind,
  output logic [rfpbl_pkg::DUR_W-1:0]     out_value,
  output logic [rfpbl_pkg::POS_W-1:0]     out_position,
  output logic                            out_half_pending,
  output logic [rfpbl_pkg::MODE_W-1:0]    out_mode,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rfpbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfpbl_pkg::DUR_W-1:0]     cfg_data
);
  import rfpbl_pkg::*;

  localparam int IDX_W  = $clog2(NUM_BUCKETS);
  localparam int USED_W = $clog2(NUM_BUCKETS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MATCH = 6'b000010,
    S_EXEC  = 6'b000100,
    S_DUMP  = 6'b001000,
    S_FEND  = 6'b010000,
    S_ABORT = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DUR_W-1:0]    footer_r, footer_nxt;
  logic [DUR_W-1:0]    pulse_r, pulse_nxt;
  logic                act_r;
  logic [DUR_W-1:0]    dur_r;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [DUR_W-1:0]    sync_r, sync_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  logic [POS_W-1:0]    bpos_r, bpos_nxt;
  logic                phase_r, phase_nxt;
  logic [NIB_W-1:0]    hi_r, hi_nxt;
  logic [USED_W-1:0]   dcnt_r, dcnt_nxt;

  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [DUR_W-1:0]    out_value_r;
  logic [POS_W-1:0]    out_pos_r;
  logic                out_half_r;
  logic [MODE_W-1:0]   out_mode_r;
  logic                out_last_r;

  logic                out_free;
  logic                emit;
  logic [KIND_W-1:0]   e_kind;
  logic [DUR_W-1:0]    e_value;
  logic [POS_W-1:0]    e_pos;
  logic                e_half;
  logic                e_last;

  logic [SUM_W-1:0]    delta;
  logic [SUM_W-1:0]    sync_fd;
  logic                near_sync;
  logic                too_long;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [POS_W-1:0]    bpos_inc;

  logic                load_en, avg_en, shift_en;
  logic [IDX_W-1:0]    tgt_idx;

  cell_ctl_t           ctl   [NUM_BUCKETS];
  logic [DUR_W-1:0]    times [NUM_BUCKETS];
  logic [DUR_W-1:0]    sh_in [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] match;

  // bucket cell row
  for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_cell
    if (g == NUM_BUCKETS - 1) begin : g_end
      assign sh_in[g] = '0;
    end else begin : g_mid
      assign sh_in[g] = times[g+1];
    end
    assign ctl[g].load  = load_en && (tgt_idx == IDX_W'(g));
    assign ctl[g].avg   = avg_en && (tgt_idx == IDX_W'(g));
    assign ctl[g].shift = shift_en;
    rfpbl_bucket_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .dur      (dur_r),
      .delta    (delta),
      .shift_in (sh_in[g]),
      .time_q   (times[g]),
      .match_r  (match[g])
    );
  end

  assign delta     = SUM_W'(dur_r >> 2) + SUM_W'(dur_r >> 3);
  assign sync_fd   = SUM_W'(sync_r >> 2);
  assign near_sync = (SUM_W'(sync_r) < SUM_W'(dur_r) + sync_fd) &&
                     (SUM_W'(dur_r) < SUM_W'(sync_r) + sync_fd);
  assign too_long  = SUM_W'(dur_r) > SUM_W'(sync_r) + sync_fd;
  assign bpos_inc  = bpos_r + POS_W'(1);

  // first matching bucket in use
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (match[i] && (USED_W'(i) < used_r)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    footer_nxt = footer_r;
    pulse_nxt  = pulse_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_FOOTER: footer_nxt = cfg_data;
        CFG_MIN_PULSE:  pulse_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    sync_nxt  = sync_r;
    used_nxt  = used_r;
    bpos_nxt  = bpos_r;
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    dcnt_nxt  = dcnt_r;
    load_en   = 1'b0;
    avg_en    = 1'b0;
    shift_en  = 1'b0;
    tgt_idx   = hit_idx;
    emit      = 1'b0;
    e_kind    = KIND_STATUS;
    e_value   = '0;
    e_pos     = '0;
    e_half    = 1'b0;
    e_last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (act_r) begin
            mode_nxt  = MODE_IDLE;
            used_nxt  = '0;
            bpos_nxt  = '0;
            phase_nxt = 1'b0;
          end else begin
            unique case (mode_r)
              MODE_IDLE: begin
                if (dur_r >= footer_r) begin
                  used_nxt = '0;
                  sync_nxt = dur_r;
                  mode_nxt = MODE_LEARN;
                end
              end
              MODE_LEARN: begin
                if (too_long) begin
                  sync_nxt = dur_r;
                  used_nxt = '0;
                end else if (near_sync && (used_r != '0)) begin
                  bpos_nxt  = '0;
                  phase_nxt = 1'b0;
                  mode_nxt  = MODE_DECODE;
                end else if (dur_r >= pulse_r) begin
                  if (hit) begin
                    avg_en = 1'b1;
                  end else if (used_r < USED_W'(NUM_BUCKETS)) begin
                    load_en  = 1'b1;
                    tgt_idx  = IDX_W'(used_r);
                    used_nxt = used_r + USED_W'(1);
                  end else begin
                    used_nxt = '0;
                    mode_nxt = MODE_IDLE;
                    e_kind   = KIND_ABORT;
                    e_value  = DUR_W'(MODE_LEARN);
                  end
                end else begin
                  mode_nxt = MODE_IDLE;
                  e_kind   = KIND_ABORT;
                  e_value  = DUR_W'(MODE_LEARN);
                end
              end
              MODE_DECODE: begin
                if (near_sync) begin
                  mode_nxt = MODE_DONE;
                  if (used_r != '0) begin
                    e_kind    = KIND_BUCKET;
                    e_value   = times[0];
                    e_last    = 1'b0;
                    shift_en  = 1'b1;
                    dcnt_nxt  = USED_W'(1);
                    state_nxt = (used_r == USED_W'(1)) ? S_FEND : S_DUMP;
                  end else begin
                    e_kind  = KIND_FEND;
                    e_value = sync_r;
                    e_pos   = bpos_r;
                    e_half  = phase_r;
                  end
                end else if (hit) begin
                  if (!phase_r) begin
                    hi_nxt    = NIB_W'(hit_idx) & NIB_MASK;
                    phase_nxt = 1'b1;
                  end else begin
                    e_kind    = KIND_DATA;
                    e_value   = DUR_W'({hi_r, NIB_W'(hit_idx) & NIB_MASK});
                    e_pos     = bpos_r;
                    bpos_nxt  = bpos_inc;
                    phase_nxt = 1'b0;
                    if (bpos_inc >= POS_W'(MAX_BYTES)) begin
                      used_nxt  = '0;
                      mode_nxt  = MODE_IDLE;
                      e_last    = 1'b0;
                      state_nxt = S_ABORT;
                    end
                  end
                end else begin
                  used_nxt = '0;
                  mode_nxt = MODE_IDLE;
                  e_kind   = KIND_ABORT;
                  e_value  = DUR_W'(MODE_DECODE);
                end
              end
              MODE_DONE: ;
              default: ;
            endcase
          end
          if (e_kind == KIND_STATUS) begin
            e_value = DUR_W'(mode_nxt);
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit     = 1'b1;
          e_kind   = KIND_BUCKET;
          e_value  = times[0];
          e_pos    = POS_W'(dcnt_r);
          e_last   = 1'b0;
          shift_en = 1'b1;
          dcnt_nxt = dcnt_r + USED_W'(1);
          if (dcnt_nxt == used_r) begin
            state_nxt = S_FEND;
          end
        end
      end
      S_FEND: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_FEND;
          e_value   = sync_r;
          e_pos     = bpos_r;
          e_half    = phase_r;
          state_nxt = S_IDLE;
        end
      end
      S_ABORT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_ABORT;
          e_value   = DUR_W'(MODE_DECODE);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      footer_r    <= FOOTER_RST;
      pulse_r     <= PULSE_RST;
      mode_r      <= MODE_IDLE;
      sync_r      <= '0;
      used_r      <= '0;
      bpos_r      <= '0;
      phase_r     <= 1'b0;
      hi_r        <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      footer_r <= footer_nxt;
      pulse_r  <= pulse_nxt;
      mode_r   <= mode_nxt;
      sync_r   <= sync_nxt;
      used_r   <= used_nxt;
      bpos_r   <= bpos_nxt;
      phase_r  <= phase_nxt;
      hi_r     <= hi_nxt;
      dcnt_r   <= dcnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act_r <= in_action;
      dur_r <= in_duration;
    end
    if (emit) begin
      out_kind_r  <= e_kind;
      out_value_r <= e_value;
      out_pos_r   <= e_pos;
      out_half_r  <= e_half;
      out_mode_r  <= mode_nxt;
      out_last_r  <= e_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_position     = out_pos_r;
  assign out_half_pending = out_half_r;
  assign out_mode         = out_mode_r;
  assign out_last         = out_last_r;

endmodule
